// ----- rtl/lpme_pkg.sv -----
// ----------------------------------------------------------------------------
// lpme_pkg
// shared types and constants of the parity message extractor
// ----------------------------------------------------------------------------
`default_nettype none

package lpme_pkg;

  localparam int POS_W       = 24;
  localparam int PC_W        = 24;
  localparam int WIN_W       = 32;
  localparam int CMP_W       = 32;
  localparam int SAMPLE_W    = 8;
  localparam int BYTE_W      = 8;
  localparam int BYTE_LOG2   = 3;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [WIN_W-1:0] START_PATTERN_RST = 32'h01FF_01FF;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PATTERN = 2'd2;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_DECODE = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic                color_mode;
    logic [PC_W-1:0]     pixel_count;
    logic [WIN_W-1:0]    start_pattern;
  } cfg_t;

  typedef struct packed {
    logic                image_start;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              fin;
  } res_t;

  typedef struct packed {
    res_t a;
    res_t b;
    logic a_vld;
    logic b_vld;
  } res_pair_t;

endpackage

`default_nettype wire

// ----- rtl/lpme_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lpme_cfg_regs
// configuration registers written through a plain indexed write port
// ----------------------------------------------------------------------------
`default_nettype none

module lpme_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lpme_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lpme_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output lpme_pkg::cfg_t                      cfg_o
);
  import lpme_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOR_MODE:    cfg_d.color_mode    = cfg_data_i[0];
        CFG_PIXEL_COUNT:   cfg_d.pixel_count   = cfg_data_i[PC_W-1:0];
        CFG_START_PATTERN: cfg_d.start_pattern = cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode    <= 1'b0;
      cfg_q.pixel_count   <= '0;
      cfg_q.start_pattern <= START_PATTERN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/lpme_in_reg.sv -----
// ----------------------------------------------------------------------------
// lpme_in_reg
// input register holding one pixel beat until the core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module lpme_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lpme_pkg::pix_t pix_i,
  input  wire logic           room_i,
  output logic                fire_o,
  output lpme_pkg::pix_t      pix_o
);
  import lpme_pkg::*;

  logic vld_q, vld_d;
  pix_t pix_q;
  logic accept;

  assign in_stall_o = vld_q & ~room_i;
  assign fire_o     = vld_q & room_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (fire_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

// ----- rtl/lpme_core.sv -----
// ----------------------------------------------------------------------------
// lpme_core
// parity bit extraction, start marker search and message byte framing
// ----------------------------------------------------------------------------
`default_nettype none

module lpme_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire lpme_pkg::cfg_t cfg_i,
  input  wire logic           fire_i,
  input  wire lpme_pkg::pix_t pix_i,
  output lpme_pkg::res_pair_t res_o
);
  import lpme_pkg::*;

  phase_e             phase_q, phase_d, ph;
  logic [POS_W-1:0]   pos_q, pos_d, pos_b, pos_n;
  logic [WIN_W-1:0]   win_q, win_d, win_b, win_n;
  logic               bit_v, boundary, late, at_end, pc_zero;
  logic [CMP_W-1:0]   pos_cmp, pc_cmp;
  res_pair_t          res;

  always_comb begin
    ph    = pix_i.image_start ? PH_SEARCH : phase_q;
    pos_b = pix_i.image_start ? '0 : pos_q;
    win_b = pix_i.image_start ? '0 : win_q;

    bit_v = cfg_i.color_mode ? (pix_i.red[0] ^ pix_i.green[0] ^ pix_i.blue[0])
                             : pix_i.red[0];
    win_n = {win_b[WIN_W-2:0], bit_v};
    pos_n = pos_b + POS_W'(1);

    pos_cmp  = CMP_W'(pos_n);
    pc_cmp   = CMP_W'(cfg_i.pixel_count);
    pc_zero  = (cfg_i.pixel_count == '0);
    boundary = (pos_n[BYTE_LOG2-1:0] == '0) ;
    // marker window needs four whole bytes
    late     = boundary && (pos_cmp >= CMP_W'(WIN_W)) && (pos_cmp >= pc_cmp - CMP_W'(1));
    at_end   = (pos_cmp == pc_cmp);
  end

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    win_d   = win_q;
    res     = '0;
    if (fire_i) begin
      phase_d = ph;
      pos_d   = pos_b;
      win_d   = win_b;
      case (ph)
        PH_SEARCH: begin
          if (pc_zero) begin
            phase_d     = PH_DONE;
            res.a_vld   = 1'b1;
            res.a.kind  = KIND_END;
            res.a.fin   = 1'b1;
          end else begin
            pos_d = pos_n;
            win_d = win_n;
            if (late) begin
              phase_d    = PH_DONE;
              res.a_vld  = 1'b1;
              res.a.kind = KIND_NONE;
              res.a.fin  = 1'b1;
            end else if (boundary && (pos_cmp >= CMP_W'(WIN_W)) &&
                         (win_n == cfg_i.start_pattern)) begin
              phase_d = PH_DECODE;
            end else if (at_end) begin
              phase_d    = PH_DONE;
              res.a_vld  = 1'b1;
              res.a.kind = KIND_NONE;
              res.a.fin  = 1'b1;
            end
          end
        end
        PH_DECODE: begin
          pos_d = pos_n;
          win_d = win_n;
          if (boundary && (win_n[BYTE_W-1:0] == '0)) begin
            phase_d    = PH_DONE;
            res.a_vld  = 1'b1;
            res.a.kind = KIND_END;
            res.a.fin  = 1'b1;
          end else begin
            if (boundary) begin
              res.a_vld  = 1'b1;
              res.a.data = win_n[BYTE_W-1:0];
              res.a.kind = KIND_BYTE;
            end
            if (at_end) begin
              phase_d = PH_DONE;
              if (boundary) begin
                res.b_vld  = 1'b1;
                res.b.kind = KIND_END;
                res.b.fin  = 1'b1;
              end else begin
                res.a_vld  = 1'b1;
                res.a.kind = KIND_END;
                res.a.fin  = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      pos_q   <= '0;
      win_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      win_q   <= win_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ----- rtl/lpme_out_queue.sv -----
// ----------------------------------------------------------------------------
// lpme_out_queue
// small result queue taking up to two results a cycle, one beat out a cycle unless out_stall_i holds it
// ----------------------------------------------------------------------------
`default_nettype none

module lpme_out_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lpme_pkg::res_pair_t res_i,
  output logic                     room_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output lpme_pkg::res_t           res_o
);
  import lpme_pkg::*;

  res_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic [QCNT_W-1:0] n_push;
  logic              pop;

  // room for two results, judged on the registered fill only
  assign room_o      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign n_push      = QCNT_W'(res_i.a_vld) + QCNT_W'(res_i.b_vld);

  always_comb begin
    wp_d  = wp_q + QPTR_W'(n_push);
    rp_d  = pop ? rp_q + QPTR_W'(1) : rp_q;
    cnt_d = cnt_q + n_push - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.a_vld) begin
      mem_q[wp_q] <= res_i.a;
    end
    if (res_i.b_vld) begin
      mem_q[wp_q + QPTR_W'(1)] <= res_i.b;
    end
  end

  assign res_o = mem_q[rp_q];

endmodule

`default_nettype wire

// ----- rtl/lsb_parity_message_extractor.sv -----
// path: a pixel beat waits in the input register until the queue has room; its results are registered in the queue
// throughput: one pixel beat per cycle while the queue has room; a pixel giving two results needs two output beats
// the four-entry result queue and its registered fill count set the input stall
// reset: asynchronous, clears search state, queue and input register, loads register defaults
// ----------------------------------------------------------------------------
// lsb_parity_message_extractor
// recovers a byte message hidden in pixel parity bits after a start marker
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_parity_message_extractor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lpme_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lpme_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            image_start_i,
  input  wire logic [lpme_pkg::SAMPLE_W-1:0]    sample_red_i,
  input  wire logic [lpme_pkg::SAMPLE_W-1:0]    sample_green_i,
  input  wire logic [lpme_pkg::SAMPLE_W-1:0]    sample_blue_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [lpme_pkg::BYTE_W-1:0]           decoded_byte_o,
  output logic [lpme_pkg::KIND_W-1:0]           result_kind_o,
  output logic                                 final_res_o
);
  import lpme_pkg::*;

  cfg_t      cfg;
  pix_t      pix_in, pix_reg;
  logic      room, fire;
  res_pair_t res_pair;
  res_t      res_out;

  assign pix_in.image_start = image_start_i;
  assign pix_in.red         = sample_red_i;
  assign pix_in.green       = sample_green_i;
  assign pix_in.blue        = sample_blue_i;

  lpme_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lpme_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pix_i      (pix_in),
    .room_i     (room),
    .fire_o     (fire),
    .pix_o      (pix_reg)
  );

  lpme_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .pix_i  (pix_reg),
    .res_o  (res_pair)
  );

  lpme_out_queue u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_pair),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign decoded_byte_o = res_out.data;
  assign result_kind_o  = res_out.kind;
  assign final_res_o    = res_out.fin;

endmodule

`default_nettype wire
